/* src/ssc_pkg.sv */
// Shared types and constants for the sparse-set component store.
package ssc_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the ports
    localparam int ACTION_W  = 3;
    localparam int KEY_IN_W  = 12;
    localparam int POS_IN_W  = 10;
    localparam int PAY_IN_W  = 32;
    localparam int STATUS_W  = 3;
    localparam int POS_OUT_W = 10;
    localparam int ENT_OUT_W = 10;
    localparam int PAY_OUT_W = 32;
    localparam int CNT_OUT_W = 11;

    // Width of the shared add/subtract unit: holds any key, position or count
    localparam int ALU_W = 18;

    typedef enum logic [ACTION_W-1:0] {
        A_INSERT  = 3'd0,
        A_REMOVE  = 3'd1,
        A_LOOKUP  = 3'd2,
        A_UPDATE  = 3'd3,
        A_READ_AT = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_DUP       = 3'd2,
        ST_FULL      = 3'd3,
        ST_KEY_RANGE = 3'd4,
        ST_POS_RANGE = 3'd5
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             borrow;
    } t_alu_res;

    // Write enables from the sequencer to the three memories
    typedef struct packed {
        logic sp_we;
        logic dk_we;
        logic dp_we;
    } t_mem_we;

endpackage

/* src/ssc_alu.sv */
// Shared add/subtract unit; a subtract also reports a < b through the borrow.
module ssc_alu (
    input  ssc_pkg::t_alu_req i_req,
    output ssc_pkg::t_alu_res o_res
);
    import ssc_pkg::*;

    logic [ALU_W:0] w_sum;

    // Extend by one bit so the top bit carries the borrow
    always_comb begin
        case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
        o_res.value  = w_sum[ALU_W-1:0];
        o_res.borrow = w_sum[ALU_W] & (i_req.op == ALU_SUB);
    end

endmodule

/* src/ssc_seq.sv */
// Sequencer: steps one request through memory reads, checks and write-backs.
module ssc_seq #(
    parameter int CAPACITY   = ssc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ssc_pkg::DATA_WIDTH_DEF,
    localparam int KEY_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ssc_pkg::ACTION_W-1:0]   i_action,
    input  logic [ssc_pkg::KEY_IN_W-1:0]   i_entity_index,
    input  logic [ssc_pkg::POS_IN_W-1:0]   i_position,
    input  logic [DATA_WIDTH-1:0]          i_payload,
    output logic                           o_busy,
    // memory side
    output ssc_pkg::t_mem_we               o_we,
    output logic [KEY_W-1:0]               o_sp_raddr,
    output logic [KEY_W-1:0]               o_sp_waddr,
    output logic [KEY_W:0]                 o_sp_wdata,
    input  logic [KEY_W:0]                 i_sp_rd,
    output logic [KEY_W-1:0]               o_dk_raddr,
    output logic [KEY_W-1:0]               o_dk_waddr,
    output logic [KEY_W-1:0]               o_dk_wdata,
    input  logic [KEY_W-1:0]               i_dk_rd,
    output logic [KEY_W-1:0]               o_dp_raddr,
    output logic [KEY_W-1:0]               o_dp_waddr,
    output logic [DATA_WIDTH-1:0]          o_dp_wdata,
    input  logic [DATA_WIDTH-1:0]          i_dp_rd,
    // shared unit
    output ssc_pkg::t_alu_req              o_alu_req,
    input  ssc_pkg::t_alu_res              i_alu_res,
    // result
    output logic                           o_valid,
    output logic [ssc_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_present,
    output logic [KEY_W-1:0]               o_dpos,
    output logic [KEY_W-1:0]               o_ent,
    output logic [DATA_WIDTH-1:0]          o_pout,
    output logic [CNT_W-1:0]               o_count
);
    import ssc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLEAR = 11'b000_0000_0010,
        S_CHK   = 11'b000_0000_0100,
        S_DEC   = 11'b000_0000_1000,
        S_DATA  = 11'b000_0001_0000,
        S_INS   = 11'b000_0010_0000,
        S_UPD   = 11'b000_0100_0000,
        S_RM1   = 11'b000_1000_0000,
        S_RM2   = 11'b001_0000_0000,
        S_RM3   = 11'b010_0000_0000,
        S_RESP  = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    t_state                w_dec_next;
    t_status               w_dec_status;
    t_status               r_status;
    logic [KEY_W-1:0]      r_clr;
    logic [CNT_W-1:0]      r_count;
    logic [ACTION_W-1:0]   r_action;
    logic [KEY_IN_W-1:0]   r_key;
    logic [POS_IN_W-1:0]   r_position;
    logic [DATA_WIDTH-1:0] r_payload;
    logic                  r_key_ok;
    logic                  r_present;
    logic [KEY_W-1:0]      r_p;
    logic [KEY_W-1:0]      r_last;
    logic [KEY_W-1:0]      r_moved;
    logic [KEY_W-1:0]      r_dpos;
    logic [KEY_W-1:0]      r_ent;
    logic [DATA_WIDTH-1:0] r_pout;
    logic [31:0]           w_in_key_ext;
    logic [31:0]           w_key_ext;
    logic [31:0]           w_pos_ext;
    logic [31:0]           w_clr_ext;
    logic [KEY_W-1:0]      w_key_a;
    logic [KEY_W-1:0]      w_pos_a;
    logic                  w_last_clr;
    logic                  w_is_read_at;
    logic                  w_sp_hit;

    // Address forms of the key and position
    assign w_in_key_ext = 32'(i_entity_index);
    assign w_key_ext    = 32'(r_key);
    assign w_pos_ext    = 32'(r_position);
    assign w_clr_ext    = 32'(r_clr);
    assign w_key_a      = w_key_ext[KEY_W-1:0];
    assign w_pos_a      = w_pos_ext[KEY_W-1:0];
    assign w_last_clr   = (w_clr_ext == 32'(CAPACITY - 1));
    assign w_is_read_at = (r_action == A_READ_AT);
    assign w_sp_hit     = i_alu_res.borrow & i_sp_rd[KEY_W];

    // Drive the shared unit from the current step
    always_comb begin
        o_alu_req.op = ALU_SUB;
        o_alu_req.a  = '0;
        o_alu_req.b  = '0;
        case (r_state)
            S_CHK: begin
                o_alu_req.a = ALU_W'(r_key);
                o_alu_req.b = ALU_W'(CAPACITY);
            end
            S_DEC: begin
                case (r_action)
                    A_READ_AT: begin
                        o_alu_req.a = ALU_W'(r_position);
                        o_alu_req.b = ALU_W'(r_count);
                    end
                    A_REMOVE: begin
                        o_alu_req.a = ALU_W'(r_count);
                        o_alu_req.b = ALU_W'(1);
                    end
                    default: begin
                        o_alu_req.a = ALU_W'(r_count);
                        o_alu_req.b = ALU_W'(CAPACITY);
                    end
                endcase
            end
            S_INS: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = ALU_W'(r_count);
                o_alu_req.b  = ALU_W'(1);
            end
            default: ;
        endcase
    end

    // Decide the path and status once key and count checks are known
    always_comb begin
        w_dec_next   = S_RESP;
        w_dec_status = ST_OK;
        if (w_is_read_at) begin
            if (i_alu_res.borrow) begin
                w_dec_next = S_DATA;
            end else begin
                w_dec_status = ST_POS_RANGE;
            end
        end else if (!r_key_ok) begin
            w_dec_status = ST_KEY_RANGE;
        end else begin
            case (r_action)
                A_INSERT: begin
                    if (r_present) begin
                        w_dec_status = ST_DUP;
                        w_dec_next   = S_DATA;
                    end else if (i_alu_res.borrow) begin
                        w_dec_next = S_INS;
                    end else begin
                        w_dec_status = ST_FULL;
                    end
                end
                A_REMOVE: begin
                    if (!r_present || r_count == '0) begin
                        w_dec_status = ST_ABSENT;
                    end else begin
                        w_dec_next = S_RM1;
                    end
                end
                A_UPDATE: begin
                    if (!r_present || r_count == '0) begin
                        w_dec_status = ST_ABSENT;
                    end else begin
                        w_dec_next = S_UPD;
                    end
                end
                A_LOOKUP: begin
                    if (!r_present || r_count == '0) begin
                        w_dec_status = ST_ABSENT;
                    end else begin
                        w_dec_next = S_DATA;
                    end
                end
                default: begin
                    if (!r_present || r_count == '0) begin
                        w_dec_status = ST_ABSENT;
                    end else begin
                        w_dec_next = S_DATA;
                    end
                end
            endcase
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (w_last_clr) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_CHK;
            S_CHK:   n_state = S_DEC;
            S_DEC:   n_state = w_dec_next;
            S_DATA:  n_state = S_RESP;
            S_INS:   n_state = S_RESP;
            S_UPD:   n_state = S_RESP;
            S_RM1:   n_state = S_RM2;
            S_RM2:   n_state = S_RM3;
            S_RM3:   n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sweep the sparse map after reset, keep the member count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_INS) r_count <= i_alu_res.value[CNT_W-1:0];
            if (r_state == S_RM3) r_count <= CNT_W'(r_last);
        end
    end

    // Request fields and result assembly
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_action   <= i_action;
                    r_key      <= i_entity_index;
                    r_position <= i_position;
                    r_payload  <= i_payload;
                    r_status   <= ST_OK;
                    r_dpos     <= '0;
                    r_ent      <= '0;
                    r_pout     <= '0;
                end
            end
            S_CHK: begin
                r_key_ok  <= i_alu_res.borrow;
                r_present <= w_sp_hit;
                r_p       <= w_sp_hit ? i_sp_rd[KEY_W-1:0] : '0;
            end
            S_DEC: begin
                r_status <= w_dec_status;
                r_last   <= i_alu_res.value[KEY_W-1:0];
                if (w_is_read_at) begin
                    if (i_alu_res.borrow) r_dpos <= w_pos_a;
                end else if (r_present) begin
                    r_dpos <= r_p;
                end
            end
            S_DATA: begin
                r_pout <= i_dp_rd;
                if (w_is_read_at) r_ent <= i_dk_rd;
            end
            S_INS: begin
                r_dpos <= r_count[KEY_W-1:0];
                r_pout <= r_payload;
            end
            S_UPD: begin
                r_pout <= r_payload;
            end
            S_RM1: begin
                r_pout  <= i_dp_rd;
                r_moved <= i_dk_rd;
            end
            default: ;
        endcase
    end

    // Read addresses: sparse on accept, dense in the decide step and for the last slot
    assign o_sp_raddr = w_in_key_ext[KEY_W-1:0];
    assign o_dk_raddr = w_is_read_at ? w_pos_a : i_alu_res.value[KEY_W-1:0];
    assign o_dp_raddr = (r_state == S_RM1) ? r_last : (w_is_read_at ? w_pos_a : r_p);

    // Write-backs per step
    always_comb begin
        o_we       = '0;
        o_sp_waddr = w_key_a;
        o_sp_wdata = '0;
        o_dk_waddr = r_p;
        o_dk_wdata = r_moved;
        o_dp_waddr = r_p;
        o_dp_wdata = i_dp_rd;
        case (r_state)
            S_CLEAR: begin
                o_we.sp_we = 1'b1;
                o_sp_waddr = r_clr;
            end
            S_INS: begin
                o_we.sp_we = 1'b1;
                o_we.dk_we = 1'b1;
                o_we.dp_we = 1'b1;
                o_sp_wdata = {1'b1, r_count[KEY_W-1:0]};
                o_dk_waddr = r_count[KEY_W-1:0];
                o_dk_wdata = w_key_a;
                o_dp_waddr = r_count[KEY_W-1:0];
                o_dp_wdata = r_payload;
            end
            S_UPD: begin
                o_we.dp_we = 1'b1;
                o_dp_wdata = r_payload;
            end
            S_RM2: begin
                // move the last entry into the freed slot and repoint its key
                o_we.sp_we = 1'b1;
                o_we.dk_we = 1'b1;
                o_we.dp_we = 1'b1;
                o_sp_waddr = r_moved;
                o_sp_wdata = {1'b1, r_p};
            end
            S_RM3: begin
                // drop the removed key last so a self-move ends absent
                o_we.sp_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_RESP);
    assign o_status  = r_status;
    assign o_present = r_present;
    assign o_dpos    = r_dpos;
    assign o_ent     = r_ent;
    assign o_pout    = r_pout;
    assign o_count   = r_count;

endmodule

/* src/sparse_set_component_store.sv */
// Sparse-set component store: a request steps through the sequencer's states over
// single-port reads of the sparse map and the dense arrays: errors go CHK, DEC, RESP;
// lookups, read-at and duplicates add DATA, insert INS, update UPD, remove RM1 to RM3,
// before RESP. The result strobe lasts one cycle, in RESP; the receiver cannot stall.
// After reset busy stays high while the sparse map is swept clear.
module sparse_set_component_store #(
    parameter int CAPACITY   = ssc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ssc_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ssc_pkg::ACTION_W-1:0]    i_action,
    input  logic [ssc_pkg::KEY_IN_W-1:0]    i_entity_index,
    input  logic [ssc_pkg::POS_IN_W-1:0]    i_position,
    input  logic [ssc_pkg::PAY_IN_W-1:0]    i_payload_in,
    output logic                            o_valid,
    output logic [ssc_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_present,
    output logic [ssc_pkg::POS_OUT_W-1:0]   o_dense_position,
    output logic [ssc_pkg::ENT_OUT_W-1:0]   o_entity_out,
    output logic [ssc_pkg::PAY_OUT_W-1:0]   o_payload_out,
    output logic [ssc_pkg::CNT_OUT_W-1:0]   o_member_count
);
    import ssc_pkg::*;

    localparam int KEY_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_mem_we               w_we;
    t_alu_req              w_alu_req;
    t_alu_res              w_alu_res;
    logic [KEY_W-1:0]      w_sp_raddr, w_sp_waddr;
    logic [KEY_W:0]        w_sp_wdata;
    logic [KEY_W-1:0]      w_dk_raddr, w_dk_waddr, w_dk_wdata;
    logic [KEY_W-1:0]      w_dp_raddr, w_dp_waddr;
    logic [DATA_WIDTH-1:0] w_dp_wdata;
    logic [DATA_WIDTH-1:0] w_payload;
    logic [KEY_W-1:0]      w_dpos, w_ent;
    logic [DATA_WIDTH-1:0] w_pout;
    logic [CNT_W-1:0]      w_count;
    logic [63:0]           w_pay_in_ext, w_pout_ext;
    logic [31:0]           w_dpos_ext, w_ent_ext, w_count_ext;

    // Sparse map entry: valid bit over dense position
    logic [KEY_W:0]        r_sparse_mem [CAPACITY];
    logic [KEY_W-1:0]      r_dkey_mem   [CAPACITY];
    logic [DATA_WIDTH-1:0] r_dpay_mem   [CAPACITY];
    logic [KEY_W:0]        r_sp_rd;
    logic [KEY_W-1:0]      r_dk_rd;
    logic [DATA_WIDTH-1:0] r_dp_rd;

    // Keep payloads to the stored width
    assign w_pay_in_ext = 64'(i_payload_in);
    assign w_payload    = w_pay_in_ext[DATA_WIDTH-1:0];

    ssc_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    ssc_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_action       (i_action),
        .i_entity_index (i_entity_index),
        .i_position     (i_position),
        .i_payload      (w_payload),
        .o_busy         (busy),
        .o_we           (w_we),
        .o_sp_raddr     (w_sp_raddr),
        .o_sp_waddr     (w_sp_waddr),
        .o_sp_wdata     (w_sp_wdata),
        .i_sp_rd        (r_sp_rd),
        .o_dk_raddr     (w_dk_raddr),
        .o_dk_waddr     (w_dk_waddr),
        .o_dk_wdata     (w_dk_wdata),
        .i_dk_rd        (r_dk_rd),
        .o_dp_raddr     (w_dp_raddr),
        .o_dp_waddr     (w_dp_waddr),
        .o_dp_wdata     (w_dp_wdata),
        .i_dp_rd        (r_dp_rd),
        .o_alu_req      (w_alu_req),
        .i_alu_res      (w_alu_res),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_present      (o_present),
        .o_dpos         (w_dpos),
        .o_ent          (w_ent),
        .o_pout         (w_pout),
        .o_count        (w_count)
    );

    // Sparse map: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we.sp_we) r_sparse_mem[w_sp_waddr] <= w_sp_wdata;
        r_sp_rd <= r_sparse_mem[w_sp_raddr];
    end

    // Dense keys
    always_ff @(posedge i_clk) begin
        if (w_we.dk_we) r_dkey_mem[w_dk_waddr] <= w_dk_wdata;
        r_dk_rd <= r_dkey_mem[w_dk_raddr];
    end

    // Dense payloads
    always_ff @(posedge i_clk) begin
        if (w_we.dp_we) r_dpay_mem[w_dp_waddr] <= w_dp_wdata;
        r_dp_rd <= r_dpay_mem[w_dp_raddr];
    end

    // Fit results to the port widths
    assign w_dpos_ext       = 32'(w_dpos);
    assign w_ent_ext        = 32'(w_ent);
    assign w_count_ext      = 32'(w_count);
    assign w_pout_ext       = 64'(w_pout);
    assign o_dense_position = w_dpos_ext[POS_OUT_W-1:0];
    assign o_entity_out     = w_ent_ext[ENT_OUT_W-1:0];
    assign o_member_count   = w_count_ext[CNT_OUT_W-1:0];
    assign o_payload_out    = w_pout_ext[PAY_OUT_W-1:0];

endmodule
